// ===== rtl/core/agseq_pkg.sv =====
// ----------------------------------------------------------------------------
// agseq_pkg
// Shared types and constants for the automatic gate sequencer.
// ----------------------------------------------------------------------------
package agseq_pkg;

    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    // Last millisecond value within one second.
    localparam logic [9:0] MS_LAST = 10'd999;

    typedef enum logic [1:0] {
        REQ_TICK     = 2'd0,
        REQ_GRANT    = 2'd1,
        REQ_REGISTER = 2'd2,
        REQ_NORMAL   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_OPENING  = 3'd1,
        MODE_OPEN     = 3'd2,
        MODE_CLOSING  = 3'd3,
        MODE_PAUSED   = 3'd4,
        MODE_BEEPS    = 3'd5,
        MODE_REGISTER = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE   = 2'd0,
        EVT_OPENED = 2'd1,
        EVT_CLOSED = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        CFG_AUTO_CLOSE = 3'd0,
        CFG_GRACE      = 3'd1,
        CFG_OPEN_STEP  = 3'd2,
        CFG_CLOSE_STEP = 3'd3,
        CFG_SETTLE     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0]  auto_close_sec;
        logic [7:0]  sensor_grace_sec;
        logic [7:0]  open_step_ms;
        logic [7:0]  close_step_ms;
        logic [10:0] relay_settle_ms;
    } cfg_t;

    // Counter commands from the sequencer.
    typedef struct packed {
        logic open_clear;
        logic open_tick;
        logic reg_load;
        logic reg_tick;
        logic reg_clear;
    } cnt_ctrl_t;

    // Counter status back to the sequencer.
    typedef struct packed {
        logic close_due;
        logic reg_zero;
    } cnt_flag_t;

endpackage

// ===== rtl/core/auto_gate_sequencer.sv =====
// ----------------------------------------------------------------------------
// auto_gate_sequencer
// Automatic gate controller with an obstruction sensor, one word per event.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Content
//  s_*       in         s_tvalid/s_tready    tick or request word
//  m_*       out        m_tvalid/m_tready    gate status word, one per input
//  cfg_*     in         cfg_valid/cfg_ready  register index and write data
//
//  Each status word is registered at the edge that accepts its input word and
//  shown from the next cycle on, so a word per cycle is sustained while m_tready
//  is high. s_tready is low only while a status word waits and m_tready is
//  low. The configuration channel is always ready. Reset (aresetn low,
//  synchronous) returns the gate to idle and closed with the default settings.
// ----------------------------------------------------------------------------
module auto_gate_sequencer #(
    parameter int unsigned CLOSED_ANGLE = 180
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] sensor_active, [12:1] register_timeout_sec, [15:13] zero
    input  logic [agseq_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] req_type
    input  logic [agseq_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [2:0] gate_mode, [10:3] servo_angle, [11] relay_on, [12] buzzer_on,
    // [20:13] close_left_sec, [28:21] grace_left_sec,
    // [40:29] register_left_sec, [42:41] gate_event, [47:43] zero
    output logic [agseq_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [agseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [agseq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    agseq_pkg::cfg_t       cfg;
    agseq_pkg::cnt_ctrl_t  ctrl;
    agseq_pkg::cnt_flag_t  flag;
    agseq_pkg::mode_t      gate_mode;
    agseq_pkg::event_t     gate_event;
    logic [7:0]            servo_angle;
    logic                  relay_on;
    logic                  buzzer_on;
    logic [7:0]            close_left_sec;
    logic [7:0]            grace_left_sec;
    logic [11:0]           register_left_sec;
    logic                  step;
    logic                  is_open;
    logic                  is_reg;

    logic                               m_tvalid_reg, m_tvalid_next;
    logic [agseq_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    agseq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    agseq_seq #(
        .CLOSED_ANGLE (CLOSED_ANGLE)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .req         (agseq_pkg::req_t'(s_tuser)),
        .sensor      (s_tdata[0]),
        .cfg         (cfg),
        .flag        (flag),
        .ctrl        (ctrl),
        .gate_mode   (gate_mode),
        .servo_angle (servo_angle),
        .relay_on    (relay_on),
        .buzzer_on   (buzzer_on),
        .gate_event  (gate_event)
    );

    agseq_cnt u_cnt (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .step              (step),
        .ctrl              (ctrl),
        .sensor            (s_tdata[0]),
        .tmo_sec           (s_tdata[12:1]),
        .cfg               (cfg),
        .flag              (flag),
        .close_left_sec    (close_left_sec),
        .grace_left_sec    (grace_left_sec),
        .register_left_sec (register_left_sec)
    );

    // Countdowns are only reported in the mode they belong to.
    assign is_open = gate_mode == agseq_pkg::MODE_OPEN;
    assign is_reg  = gate_mode == agseq_pkg::MODE_REGISTER;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (step) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {5'b00000,
                             gate_event,
                             is_reg  ? register_left_sec : 12'd0,
                             is_open ? grace_left_sec    : 8'd0,
                             is_open ? close_left_sec    : 8'd0,
                             buzzer_on,
                             relay_on,
                             servo_angle,
                             gate_mode};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/core/agseq_cfg.sv =====
// ----------------------------------------------------------------------------
// agseq_cfg
// Configuration register bank, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module agseq_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [agseq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [agseq_pkg::CFG_DATA_W-1:0]    cfg_data,
    output agseq_pkg::cfg_t                     cfg
);

    agseq_pkg::cfg_t cfg_reg;
    agseq_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                agseq_pkg::CFG_AUTO_CLOSE: cfg_next.auto_close_sec   = cfg_data[7:0];
                agseq_pkg::CFG_GRACE:      cfg_next.sensor_grace_sec = cfg_data[7:0];
                agseq_pkg::CFG_OPEN_STEP:  cfg_next.open_step_ms     = cfg_data[7:0];
                agseq_pkg::CFG_CLOSE_STEP: cfg_next.close_step_ms    = cfg_data[7:0];
                agseq_pkg::CFG_SETTLE:     cfg_next.relay_settle_ms  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.auto_close_sec   <= 8'd15;
            cfg_reg.sensor_grace_sec <= 8'd5;
            cfg_reg.open_step_ms     <= 8'd15;
            cfg_reg.close_step_ms    <= 8'd25;
            cfg_reg.relay_settle_ms  <= 11'd500;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/core/agseq_cnt.sv =====
// ----------------------------------------------------------------------------
// agseq_cnt
// Open-time, sensor-idle and register-mode counters, kept as seconds plus
// milliseconds so that the second counts come out without a divider.
// ----------------------------------------------------------------------------
module agseq_cnt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  agseq_pkg::cnt_ctrl_t  ctrl,
    input  logic                  sensor,
    input  logic [11:0]           tmo_sec,
    input  agseq_pkg::cfg_t       cfg,
    output agseq_pkg::cnt_flag_t  flag,
    output logic [7:0]            close_left_sec,
    output logic [7:0]            grace_left_sec,
    output logic [11:0]           register_left_sec
);

    // The up-counting second counts saturate once the top bit is set, which is beyond any limit.
    logic [8:0]  oe_s_reg, oe_s_next, oe_s_inc;
    logic [9:0]  oe_m_reg, oe_m_next, oe_m_inc;
    logic [8:0]  ss_s_reg, ss_s_next, ss_s_inc;
    logic [9:0]  ss_m_reg, ss_m_next, ss_m_inc;
    logic [11:0] rg_s_reg, rg_s_next;
    logic [9:0]  rg_m_reg, rg_m_next;

    always_comb begin
        oe_s_inc = oe_s_reg;
        oe_m_inc = oe_m_reg;
        if (!oe_s_reg[8]) begin
            if (oe_m_reg == agseq_pkg::MS_LAST) begin
                oe_m_inc = '0;
                oe_s_inc = oe_s_reg + 9'd1;
            end else begin
                oe_m_inc = oe_m_reg + 10'd1;
            end
        end
        ss_s_inc = ss_s_reg;
        ss_m_inc = ss_m_reg;
        if (!ss_s_reg[8]) begin
            if (ss_m_reg == agseq_pkg::MS_LAST) begin
                ss_m_inc = '0;
                ss_s_inc = ss_s_reg + 9'd1;
            end else begin
                ss_m_inc = ss_m_reg + 10'd1;
            end
        end
    end

    assign flag.close_due = !sensor
                            && (oe_s_inc >= {1'b0, cfg.auto_close_sec})
                            && (ss_s_inc >= {1'b0, cfg.sensor_grace_sec});
    assign flag.reg_zero  = (rg_s_reg == '0) && (rg_m_reg == '0);

    always_comb begin
        oe_s_next = oe_s_reg;
        oe_m_next = oe_m_reg;
        ss_s_next = ss_s_reg;
        ss_m_next = ss_m_reg;
        rg_s_next = rg_s_reg;
        rg_m_next = rg_m_reg;
        if (step) begin
            if (ctrl.open_clear) begin
                oe_s_next = '0;
                oe_m_next = '0;
                ss_s_next = '0;
                ss_m_next = '0;
            end else if (ctrl.open_tick) begin
                oe_s_next = oe_s_inc;
                oe_m_next = oe_m_inc;
                ss_s_next = sensor ? 9'd0 : ss_s_inc;
                ss_m_next = sensor ? 10'd0 : ss_m_inc;
            end
            if (ctrl.reg_load) begin
                rg_s_next = tmo_sec;
                rg_m_next = '0;
            end else if (ctrl.reg_clear) begin
                rg_s_next = '0;
                rg_m_next = '0;
            end else if (ctrl.reg_tick && !flag.reg_zero) begin
                if (rg_m_reg == '0) begin
                    rg_s_next = rg_s_reg - 12'd1;
                    rg_m_next = agseq_pkg::MS_LAST;
                end else begin
                    rg_m_next = rg_m_reg - 10'd1;
                end
            end
        end
    end

    // A partial second rounds up, so the ceiling is simply limit minus whole seconds.
    assign close_left_sec = (oe_s_next < {1'b0, cfg.auto_close_sec})
                            ? cfg.auto_close_sec - oe_s_next[7:0] : 8'd0;
    assign grace_left_sec = (ss_s_next < {1'b0, cfg.sensor_grace_sec})
                            ? cfg.sensor_grace_sec - ss_s_next[7:0] : 8'd0;
    assign register_left_sec = rg_s_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oe_s_reg <= '0;
            oe_m_reg <= '0;
            ss_s_reg <= '0;
            ss_m_reg <= '0;
            rg_s_reg <= '0;
            rg_m_reg <= '0;
        end else begin
            oe_s_reg <= oe_s_next;
            oe_m_reg <= oe_m_next;
            ss_s_reg <= ss_s_next;
            ss_m_reg <= ss_m_next;
            rg_s_reg <= rg_s_next;
            rg_m_reg <= rg_m_next;
        end
    end

endmodule

// ===== rtl/core/agseq_seq.sv =====
// ----------------------------------------------------------------------------
// agseq_seq
// Gate sequencer: open and close phases, servo ramp, relay and buzzer levels.
// ----------------------------------------------------------------------------
module agseq_seq #(
    parameter int unsigned CLOSED_ANGLE = 180
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  agseq_pkg::req_t       req,
    input  logic                  sensor,
    input  agseq_pkg::cfg_t       cfg,
    input  agseq_pkg::cnt_flag_t  flag,
    output agseq_pkg::cnt_ctrl_t  ctrl,
    output agseq_pkg::mode_t      gate_mode,
    output logic [7:0]            servo_angle,
    output logic                  relay_on,
    output logic                  buzzer_on,
    output agseq_pkg::event_t     gate_event
);

    localparam logic [7:0]  ANGLE_CLOSED   = 8'(CLOSED_ANGLE);
    localparam logic [11:0] CHIRP_MS       = 12'd20;
    localparam logic [11:0] BEEP_ON_MS     = 12'd100;
    localparam logic [11:0] BEEP_PERIOD_MS = 12'd150;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_OP_PRE    = 12'b0000_0000_0010,
        ST_OP_RAMP   = 12'b0000_0000_0100,
        ST_OP_POST   = 12'b0000_0000_1000,
        ST_OPEN      = 12'b0000_0001_0000,
        ST_CL_PRE    = 12'b0000_0010_0000,
        ST_CL_RELAY  = 12'b0000_0100_0000,
        ST_CL_WAIT   = 12'b0000_1000_0000,
        ST_CL_RESUME = 12'b0001_0000_0000,
        ST_PAUSED    = 12'b0010_0000_0000,
        ST_BEEPS     = 12'b0100_0000_0000,
        ST_REGISTER  = 12'b1000_0000_0000
    } state_t;

    // Multiple of 15 test: a * 137 >> 11 is the exact quotient for 8-bit a.
    function automatic logic is_mult15(input logic [7:0] a);
        logic [15:0] prod;
        logic [7:0]  back;
        prod = 16'(a) * 16'd137;
        back = {3'b000, prod[15:11]} * 8'd15;
        return back == a;
    endfunction

    function automatic agseq_pkg::mode_t mode_of(input state_t s);
        case (s)
            ST_OP_PRE, ST_OP_RAMP, ST_OP_POST:            return agseq_pkg::MODE_OPENING;
            ST_OPEN:                                      return agseq_pkg::MODE_OPEN;
            ST_CL_PRE, ST_CL_RELAY, ST_CL_WAIT, ST_CL_RESUME:
                                                          return agseq_pkg::MODE_CLOSING;
            ST_PAUSED:                                    return agseq_pkg::MODE_PAUSED;
            ST_BEEPS:                                     return agseq_pkg::MODE_BEEPS;
            ST_REGISTER:                                  return agseq_pkg::MODE_REGISTER;
            default:                                      return agseq_pkg::MODE_IDLE;
        endcase
    endfunction

    state_t      state_reg, state_next;
    logic [7:0]  angle_reg, angle_next;
    logic [7:0]  pos_reg, pos_next;
    logic [11:0] timer_reg, timer_next;
    logic        relay_reg, relay_next;
    logic        buzz_reg, buzz_next;
    logic [1:0]  beep_reg, beep_next;

    logic [11:0] timer_inc;
    logic        settle_done;
    logic        chirp_now;
    logic [8:0]  close_total;
    logic [1:0]  beep_inc;
    logic [7:0]  write_pos;
    logic        do_check;
    logic        do_write;
    agseq_pkg::event_t evt;

    assign timer_inc   = timer_reg + 12'd1;
    assign settle_done = timer_inc >= {1'b0, cfg.relay_settle_ms};
    assign chirp_now   = is_mult15(angle_reg);
    assign close_total = {1'b0, cfg.close_step_ms} + (chirp_now ? 9'(CHIRP_MS) : 9'd0);
    assign beep_inc    = beep_reg + 2'd1;

    // The pending degree: the current one after the relay settles, the held one
    // after a pause, otherwise one step further towards closed.
    always_comb begin
        case (state_reg)
            ST_CL_RELAY:  write_pos = angle_reg;
            ST_CL_RESUME: write_pos = pos_reg;
            default:      write_pos = angle_reg + 8'd1;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        angle_next = angle_reg;
        pos_next   = pos_reg;
        timer_next = timer_reg;
        relay_next = relay_reg;
        buzz_next  = buzz_reg;
        beep_next  = beep_reg;
        ctrl       = '0;
        evt        = agseq_pkg::EVT_NONE;
        do_check   = 1'b0;
        do_write   = 1'b0;
        if (step) begin
            case (req)
                agseq_pkg::REQ_TICK: begin
                    case (state_reg)
                        ST_OP_PRE: begin
                            timer_next = timer_inc;
                            if (settle_done) begin
                                state_next = ST_OP_RAMP;
                                timer_next = '0;
                            end
                        end
                        ST_OP_RAMP: begin
                            timer_next = timer_inc;
                            if (timer_inc >= {4'b0000, cfg.open_step_ms}) begin
                                timer_next = '0;
                                if (angle_reg == '0) begin
                                    state_next = ST_OP_POST;
                                end else begin
                                    angle_next = angle_reg - 8'd1;
                                end
                            end
                        end
                        ST_OP_POST: begin
                            timer_next = timer_inc;
                            if (settle_done) begin
                                relay_next      = 1'b0;
                                state_next      = ST_OPEN;
                                timer_next      = '0;
                                ctrl.open_clear = 1'b1;
                                evt             = agseq_pkg::EVT_OPENED;
                            end
                        end
                        ST_OPEN: begin
                            ctrl.open_tick = 1'b1;
                            buzz_next      = sensor;
                            if (flag.close_due) begin
                                state_next = ST_CL_PRE;
                                timer_next = '0;
                            end
                        end
                        ST_CL_PRE: begin
                            timer_next = timer_inc;
                            if (settle_done) begin
                                relay_next = 1'b1;
                                state_next = ST_CL_RELAY;
                                timer_next = '0;
                            end
                        end
                        ST_CL_RELAY: begin
                            timer_next = timer_inc;
                            do_check   = settle_done;
                        end
                        ST_CL_RESUME: begin
                            timer_next = timer_inc;
                            do_write   = settle_done;
                        end
                        ST_CL_WAIT: begin
                            timer_next = timer_inc;
                            buzz_next  = chirp_now && (timer_inc < CHIRP_MS);
                            if (timer_inc >= {3'b000, close_total}) begin
                                timer_next = '0;
                                if (angle_reg >= ANGLE_CLOSED) begin
                                    relay_next = 1'b0;
                                    state_next = ST_BEEPS;
                                    beep_next  = '0;
                                    buzz_next  = 1'b1;
                                    evt        = agseq_pkg::EVT_CLOSED;
                                end else begin
                                    do_check = 1'b1;
                                end
                            end
                        end
                        ST_PAUSED: begin
                            if (!sensor) begin
                                buzz_next  = 1'b0;
                                relay_next = 1'b1;
                                state_next = ST_CL_RESUME;
                                timer_next = '0;
                            end
                        end
                        ST_BEEPS: begin
                            timer_next = timer_inc;
                            buzz_next  = timer_inc < BEEP_ON_MS;
                            if (timer_inc >= BEEP_PERIOD_MS) begin
                                timer_next = '0;
                                beep_next  = beep_inc;
                                buzz_next  = 1'b1;
                                if (beep_inc >= 2'd2) begin
                                    beep_next  = '0;
                                    buzz_next  = 1'b0;
                                    state_next = ST_IDLE;
                                end
                            end
                        end
                        ST_REGISTER: begin
                            ctrl.reg_tick = 1'b1;
                            if (flag.reg_zero) begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                agseq_pkg::REQ_GRANT: begin
                    if (state_reg == ST_IDLE || state_reg == ST_OPEN
                            || state_reg == ST_REGISTER) begin
                        state_next     = ST_OP_PRE;
                        timer_next     = '0;
                        relay_next     = 1'b1;
                        ctrl.reg_clear = 1'b1;
                    end
                end
                agseq_pkg::REQ_REGISTER: begin
                    if (state_reg == ST_IDLE || state_reg == ST_REGISTER) begin
                        state_next    = ST_REGISTER;
                        ctrl.reg_load = 1'b1;
                    end
                end
                default: begin
                    if (state_reg == ST_REGISTER) begin
                        state_next     = ST_IDLE;
                        ctrl.reg_clear = 1'b1;
                    end
                end
            endcase
            // An object in the way stops the ramp before the degree is written.
            if (do_check && sensor) begin
                pos_next   = write_pos;
                state_next = ST_PAUSED;
                relay_next = 1'b0;
                buzz_next  = 1'b1;
            end else if (do_check || do_write) begin
                pos_next   = write_pos;
                angle_next = write_pos;
                state_next = ST_CL_WAIT;
                timer_next = '0;
                buzz_next  = is_mult15(write_pos);
            end
        end
    end

    assign gate_mode   = mode_of(state_next);
    assign servo_angle = angle_next;
    assign relay_on    = relay_next;
    assign buzzer_on   = buzz_next;
    assign gate_event  = evt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            angle_reg <= ANGLE_CLOSED;
            pos_reg   <= '0;
            timer_reg <= '0;
            relay_reg <= 1'b0;
            buzz_reg  <= 1'b0;
            beep_reg  <= '0;
        end else begin
            state_reg <= state_next;
            angle_reg <= angle_next;
            pos_reg   <= pos_next;
            timer_reg <= timer_next;
            relay_reg <= relay_next;
            buzz_reg  <= buzz_next;
            beep_reg  <= beep_next;
        end
    end

endmodule

// ===== verif/auto_gate_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_gate_sequencer_tb
// Self-checking bench for the automatic gate sequencer. A behavioural model
// of the gate predicts the status word for every accepted request word. The
// monitor compares each status word field by field against the model. The
// stimulus runs a short directed opening and then randomised open and close
// cycles, register visits and noise under five register settings. Both
// stream sides idle and stall at random, and the receiver holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module auto_gate_sequencer_tb;

    import agseq_pkg::*;

    localparam int CLOSED_DEG     = 180;
    localparam int CHIRP_MS       = 20;
    localparam int BEEP_ON_MS     = 100;
    localparam int BEEP_PERIOD_MS = 150;
    localparam int COUNT_MAX      = 262143;

    // Position within a movement sequence.
    typedef enum logic [2:0] {
        STEP_NONE,
        OPEN_SETTLE,
        OPEN_RAMP,
        OPEN_SETTLE_OFF,
        CLOSE_DELAY,
        CLOSE_SETTLE,
        CLOSE_WAIT,
        CLOSE_RESUME
    } step_e;

    typedef struct packed {
        logic [1:0]  req;
        logic        sensor;
        logic [11:0] timeout;
    } gate_word_s;

    // Laid out as m_tdata[42:0], lowest field last.
    typedef struct packed {
        logic [1:0]  gate_event;
        logic [11:0] register_left;
        logic [7:0]  grace_left;
        logic [7:0]  close_left;
        logic        buzzer;
        logic        relay;
        logic [7:0]  angle;
        logic [2:0]  mode;
    } gate_status_s;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    auto_gate_sequencer #(
        .CLOSED_ANGLE(CLOSED_DEG)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    gate_word_s   pending_words[$];
    gate_status_s expected_status[$];
    gate_word_s   bus_word;

    int words_queued  = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int fault_count   = 0;
    int opened_seen   = 0;
    int closed_seen   = 0;
    int paused_seen   = 0;
    int burst_left    = 1;
    int gap_left      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int ready_clock   = 0;
    int stall_pct     = 0;
    logic sensor_level = 1'b0;

    // Model of the gate.
    cfg_t         model_cfg;
    mode_t        g_mode;
    step_e        g_step;
    logic [7:0]   g_angle;
    logic [7:0]   g_next_angle;
    logic [15:0]  g_timer;
    logic [17:0]  g_open_ms;
    logic [17:0]  g_quiet_ms;
    logic [21:0]  g_reg_ms;
    logic [1:0]   g_beeps;
    logic         g_relay;
    logic         g_buzz;
    event_t       g_event;

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got,
                                          int index);
        if (want != got) begin
            note_fault($sformatf("status word %0d: %s expected %0d, got %0d",
                                 index, name, want, got));
        end
    endfunction

    function automatic logic settle_done();
        g_timer = g_timer + 16'd1;
        return g_timer >= model_cfg.relay_settle_ms;
    endfunction

    function automatic logic [17:0] count_up(logic [17:0] v);
        return (v >= COUNT_MAX) ? v : v + 18'd1;
    endfunction

    function automatic logic [7:0] secs_left(int unsigned limit_ms, int unsigned done_ms);
        int unsigned s;
        if (done_ms >= limit_ms) begin
            return 8'd0;
        end
        s = (limit_ms - done_ms + 999) / 1000;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function automatic void write_close_angle();
        g_angle = g_next_angle;
        g_step  = CLOSE_WAIT;
        g_timer = '0;
        g_buzz  = (g_angle % 15) == 0;
    endfunction

    // An object in the way stops the ramp before the next degree is written.
    function automatic void close_or_pause(logic sensor);
        if (sensor) begin
            g_mode  = MODE_PAUSED;
            g_relay = 1'b0;
            g_buzz  = 1'b1;
        end else begin
            write_close_angle();
        end
    endfunction

    function automatic void gate_tick(logic sensor);
        logic        chirp;
        int unsigned total;
        case (g_mode)
            MODE_OPENING: begin
                if (g_step == OPEN_SETTLE) begin
                    if (settle_done()) begin
                        g_step  = OPEN_RAMP;
                        g_timer = '0;
                    end
                end else if (g_step == OPEN_RAMP) begin
                    g_timer = g_timer + 16'd1;
                    if (g_timer >= model_cfg.open_step_ms) begin
                        g_timer = '0;
                        if (g_angle == 0) begin
                            g_step = OPEN_SETTLE_OFF;
                        end else begin
                            g_angle = g_angle - 8'd1;
                        end
                    end
                end else if (settle_done()) begin
                    g_relay    = 1'b0;
                    g_mode     = MODE_OPEN;
                    g_step     = STEP_NONE;
                    g_timer    = '0;
                    g_open_ms  = '0;
                    g_quiet_ms = '0;
                    g_event    = EVT_OPENED;
                end
            end
            MODE_OPEN: begin
                g_open_ms  = count_up(g_open_ms);
                g_quiet_ms = sensor ? 18'd0 : count_up(g_quiet_ms);
                g_buzz     = sensor;
                if (!sensor && 32'(g_open_ms) >= 32'(model_cfg.auto_close_sec) * 1000 &&
                    32'(g_quiet_ms) >= 32'(model_cfg.sensor_grace_sec) * 1000) begin
                    g_mode  = MODE_CLOSING;
                    g_step  = CLOSE_DELAY;
                    g_timer = '0;
                end
            end
            MODE_CLOSING: begin
                if (g_step == CLOSE_DELAY) begin
                    if (settle_done()) begin
                        g_relay = 1'b1;
                        g_step  = CLOSE_SETTLE;
                        g_timer = '0;
                    end
                end else if (g_step == CLOSE_SETTLE) begin
                    if (settle_done()) begin
                        g_next_angle = g_angle;
                        close_or_pause(sensor);
                    end
                end else if (g_step == CLOSE_RESUME) begin
                    if (settle_done()) begin
                        write_close_angle();
                    end
                end else begin
                    chirp   = (g_angle % 15) == 0;
                    total   = 32'(model_cfg.close_step_ms) + (chirp ? CHIRP_MS : 0);
                    g_timer = g_timer + 16'd1;
                    g_buzz  = chirp && g_timer < CHIRP_MS;
                    if (g_timer >= total) begin
                        g_timer = '0;
                        if (g_angle >= CLOSED_DEG) begin
                            g_relay = 1'b0;
                            g_mode  = MODE_BEEPS;
                            g_step  = STEP_NONE;
                            g_beeps = '0;
                            g_buzz  = 1'b1;
                            g_event = EVT_CLOSED;
                        end else begin
                            g_next_angle = g_angle + 8'd1;
                            close_or_pause(sensor);
                        end
                    end
                end
            end
            MODE_PAUSED: begin
                if (!sensor) begin
                    g_buzz  = 1'b0;
                    g_relay = 1'b1;
                    g_mode  = MODE_CLOSING;
                    g_step  = CLOSE_RESUME;
                    g_timer = '0;
                end
            end
            MODE_BEEPS: begin
                g_timer = g_timer + 16'd1;
                g_buzz  = g_timer < BEEP_ON_MS;
                if (g_timer >= BEEP_PERIOD_MS) begin
                    g_timer = '0;
                    g_beeps = g_beeps + 2'd1;
                    g_buzz  = 1'b1;
                    if (g_beeps >= 2) begin
                        g_beeps = '0;
                        g_buzz  = 1'b0;
                        g_mode  = MODE_IDLE;
                    end
                end
            end
            MODE_REGISTER: begin
                if (g_reg_ms == 0) begin
                    g_mode = MODE_IDLE;
                end else begin
                    g_reg_ms = g_reg_ms - 22'd1;
                end
            end
            default: ;
        endcase
    endfunction

    // Applies one accepted request word and queues the status it must produce.
    function automatic void advance_gate(gate_word_s word);
        gate_status_s st;
        g_event = EVT_NONE;
        case (word.req)
            REQ_TICK: gate_tick(word.sensor);
            REQ_GRANT: begin
                if (g_mode == MODE_IDLE || g_mode == MODE_OPEN || g_mode == MODE_REGISTER) begin
                    g_mode   = MODE_OPENING;
                    g_step   = OPEN_SETTLE;
                    g_timer  = '0;
                    g_relay  = 1'b1;
                    g_reg_ms = '0;
                end
            end
            REQ_REGISTER: begin
                if (g_mode == MODE_IDLE || g_mode == MODE_REGISTER) begin
                    g_mode   = MODE_REGISTER;
                    g_reg_ms = 22'(32'(word.timeout) * 1000);
                end
            end
            default: begin
                if (g_mode == MODE_REGISTER) begin
                    g_mode   = MODE_IDLE;
                    g_reg_ms = '0;
                end
            end
        endcase
        st.mode       = g_mode;
        st.angle      = g_angle;
        st.relay      = g_relay;
        st.buzzer     = g_buzz;
        st.close_left = (g_mode == MODE_OPEN) ?
            secs_left(32'(model_cfg.auto_close_sec) * 1000, 32'(g_open_ms)) : 8'd0;
        st.grace_left = (g_mode == MODE_OPEN) ?
            secs_left(32'(model_cfg.sensor_grace_sec) * 1000, 32'(g_quiet_ms)) : 8'd0;
        st.register_left = (g_mode == MODE_REGISTER) ? 12'(g_reg_ms / 1000) : 12'd0;
        st.gate_event    = g_event;
        expected_status.push_back(st);
    endfunction

    // Sender: bursts of words from the pending queue with random gaps between.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_gate(bus_word);
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    bus_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= bus_word.req;
                    s_tdata  <= {3'b000, bus_word.timeout, bus_word.sensor};
                    words_sent++;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls at a changing rate; one long hold-off while
    // the sender is still offering words, so that the block backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && words_checked >= 400 && s_tvalid) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            if (ready_clock == 0) begin
                case ($urandom_range(4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            ready_clock = (ready_clock + 1) % 64;
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : status_monitor
        gate_status_s got;
        gate_status_s want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[42:0];
            if (expected_status.size() == 0) begin
                note_fault($sformatf("status word %0d arrived with none expected",
                                     words_checked));
            end else begin
                want = expected_status.pop_front();
                compare_field("gate_mode", want.mode, got.mode, words_checked);
                compare_field("servo_angle", want.angle, got.angle, words_checked);
                compare_field("relay_on", want.relay, got.relay, words_checked);
                compare_field("buzzer_on", want.buzzer, got.buzzer, words_checked);
                compare_field("close_left_sec", want.close_left, got.close_left,
                              words_checked);
                compare_field("grace_left_sec", want.grace_left, got.grace_left,
                              words_checked);
                compare_field("register_left_sec", want.register_left, got.register_left,
                              words_checked);
                compare_field("gate_event", want.gate_event, got.gate_event, words_checked);
                if (want.gate_event == EVT_OPENED) opened_seen++;
                if (want.gate_event == EVT_CLOSED) closed_seen++;
                if (want.mode == MODE_PAUSED) paused_seen++;
            end
            words_checked++;
        end
    end

    task automatic push_word(input logic [1:0] req, input logic sensor,
                             input logic [11:0] timeout);
        gate_word_s w;
        w.req     = req;
        w.sensor  = sensor;
        w.timeout = timeout;
        pending_words.push_back(w);
        words_queued++;
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [10:0] value);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_AUTO_CLOSE: model_cfg.auto_close_sec   = value[7:0];
            CFG_GRACE:      model_cfg.sensor_grace_sec = value[7:0];
            CFG_OPEN_STEP:  model_cfg.open_step_ms     = value[7:0];
            CFG_CLOSE_STEP: model_cfg.close_step_ms    = value[7:0];
            CFG_SETTLE:     model_cfg.relay_settle_ms  = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_quiet();
        while (pending_words.size() != 0 || words_checked < words_sent) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // The sensor mostly reads clear, with short obstructions now and then.
    function automatic logic wander_sensor();
        if (sensor_level) begin
            sensor_level = ($urandom_range(7) != 0);
        end else begin
            sensor_level = ($urandom_range(59) == 0);
        end
        return sensor_level;
    endfunction

    task automatic push_tick_or_noise();
        if ($urandom_range(49) == 0) begin
            push_word($urandom_range(1, 3), $urandom_range(1), $urandom_range(3600));
        end else begin
            push_word(REQ_TICK, wander_sensor(), $urandom_range(3600));
        end
    endtask

    // Grant, then feed ticks until the model reports the gate idle again or the cap is spent.
    task automatic run_gate_cycle(input int cap);
        int spent;
        spent = 0;
        push_word(REQ_GRANT, $urandom_range(1), $urandom_range(3600));
        do begin
            repeat (16) push_tick_or_noise();
            spent += 16;
            while (pending_words.size() > 2) @(posedge aclk);
        end while (spent < cap && g_mode != MODE_IDLE);
    endtask

    task automatic run_register_visit();
        int pick;
        pick = $urandom_range(9);
        push_word(REQ_REGISTER, $urandom_range(1),
                  (pick < 5) ? 12'd0 : (pick < 8) ? 12'($urandom_range(1, 3))
                                                  : 12'($urandom_range(3600)));
        repeat ($urandom_range(2, 40)) push_word(REQ_TICK, $urandom_range(1),
                                                 $urandom_range(3600));
        case ($urandom_range(3))
            0: push_word(REQ_NORMAL, $urandom_range(1), $urandom_range(3600));
            1: push_word(REQ_REGISTER, $urandom_range(1), $urandom_range(3600));
            2: push_word(REQ_GRANT, $urandom_range(1), $urandom_range(3600));
            default: ;
        endcase
    endtask

    task automatic run_phase(input int budget, input int cycle_cap);
        int stop_at;
        int pick;
        stop_at = words_queued + budget;
        while (words_queued < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                run_gate_cycle(cycle_cap);
            end else if (pick < 85) begin
                run_register_visit();
            end else begin
                repeat ($urandom_range(3, 20)) push_word($urandom_range(3), $urandom_range(1),
                                                         $urandom_range(3600));
            end
        end
        wait_quiet();
    endtask

    initial begin
        #8_000_000;
        $display("auto_gate_sequencer verification failed");
        $finish;
    end

    initial begin
        model_cfg.auto_close_sec   = 8'd15;
        model_cfg.sensor_grace_sec = 8'd5;
        model_cfg.open_step_ms     = 8'd15;
        model_cfg.close_step_ms    = 8'd25;
        model_cfg.relay_settle_ms  = 11'd500;
        g_mode       = MODE_IDLE;
        g_step       = STEP_NONE;
        g_angle      = 8'(CLOSED_DEG);
        g_next_angle = '0;
        g_timer      = '0;
        g_open_ms    = '0;
        g_quiet_ms   = '0;
        g_reg_ms     = '0;
        g_beeps      = '0;
        g_relay      = 1'b0;
        g_buzz       = 1'b0;
        g_event      = EVT_NONE;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at the reset settings: requests that must be
        // ignored, register timeout and reload, and a grant out of register.
        push_word(REQ_TICK, 1'b0, 12'd0);
        push_word(REQ_TICK, 1'b1, 12'hFFF & 12'd3600);
        push_word(REQ_NORMAL, 1'b0, 12'd0);
        push_word(REQ_REGISTER, 1'b0, 12'd0);
        push_word(REQ_TICK, 1'b0, 12'd0);
        push_word(REQ_TICK, 1'b1, 12'd0);
        push_word(REQ_REGISTER, 1'b1, 12'd3600);
        push_word(REQ_TICK, 1'b0, 12'd0);
        push_word(REQ_REGISTER, 1'b0, 12'd2047);
        push_word(REQ_TICK, 1'b1, 12'd1);
        push_word(REQ_NORMAL, 1'b1, 12'd0);
        push_word(REQ_NORMAL, 1'b0, 12'd0);
        push_word(REQ_REGISTER, 1'b0, 12'd1);
        push_word(REQ_GRANT, 1'b1, 12'd0);
        push_word(REQ_GRANT, 1'b0, 12'd0);
        push_word(REQ_REGISTER, 1'b1, 12'd2048);
        push_word(REQ_NORMAL, 1'b0, 12'd0);
        push_word(REQ_TICK, 1'b1, 12'd0);
        push_word(REQ_TICK, 1'b0, 12'd0);
        wait_quiet();

        // Fastest settings: full cycles with pauses, chirps and beeps.
        write_register(CFG_AUTO_CLOSE, 11'd0);
        write_register(CFG_GRACE, 11'd0);
        write_register(CFG_OPEN_STEP, 11'd1);
        write_register(CFG_CLOSE_STEP, 11'd1);
        write_register(CFG_SETTLE, 11'd0);
        run_phase(800, 1400);

        // Dwell in the open state to watch the countdowns; grants reopen.
        write_register(CFG_AUTO_CLOSE, 11'($urandom_range(1, 3)));
        write_register(CFG_GRACE, 11'($urandom_range(1, 2)));
        write_register(CFG_SETTLE, 11'd2);
        run_phase(300, 200);

        // Zero step periods behave as a single tick.
        write_register(CFG_AUTO_CLOSE, 11'd0);
        write_register(CFG_GRACE, 11'd0);
        write_register(CFG_OPEN_STEP, 11'd0);
        write_register(CFG_CLOSE_STEP, 11'd0);
        write_register(CFG_SETTLE, 11'($urandom_range(0, 3)));
        run_phase(400, 1200);

        // Largest values: only the early part of each sequence is reached.
        write_register(CFG_AUTO_CLOSE, 11'd255);
        write_register(CFG_GRACE, 11'd255);
        write_register(CFG_OPEN_STEP, 11'd255);
        write_register(CFG_CLOSE_STEP, 11'd255);
        write_register(CFG_SETTLE, 11'd2047);
        run_phase(60, 60);

        write_register(CFG_AUTO_CLOSE, 11'd0);
        write_register(CFG_GRACE, 11'($urandom_range(0, 1)));
        write_register(CFG_OPEN_STEP, 11'($urandom_range(1, 2)));
        write_register(CFG_CLOSE_STEP, 11'($urandom_range(1, 2)));
        write_register(CFG_SETTLE, 11'($urandom_range(0, 20)));
        run_phase(300, 1500);

        if (expected_status.size() != 0) begin
            note_fault($sformatf("%0d status words never arrived", expected_status.size()));
        end
        $display("Checked %0d status words under five register settings.", words_checked);
        $display("Gate opened %0d times, closed %0d times, %0d words paused on an obstruction.",
                 opened_seen, closed_seen, paused_seen);
        if (fault_count == 0) begin
            $display("auto_gate_sequencer verification clean");
        end else begin
            $display("auto_gate_sequencer verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/agseq_pkg.sv
rtl/core/agseq_cfg.sv
rtl/core/agseq_cnt.sv
rtl/core/agseq_seq.sv
rtl/core/auto_gate_sequencer.sv
verif/auto_gate_sequencer_tb.sv
